// ===== design/assert_macros.svh =====
// assertion macros shared by the fraction arithmetic design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define RAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rar assertion failed");

// condition must never be seen outside reset
`define RAR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rar forbidden condition");

`endif

// ===== design/rar_pkg.sv =====
// shared types and constants for the fraction arithmetic design
`timescale 1ns / 1ps

package rar_pkg;

  // operand magnitude, product and reduced value widths
  localparam int OPM_W  = 17;
  localparam int PROD_W = 2 * OPM_W;
  localparam int MAG_W  = 33;

  // operation codes
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] num_a;
    logic signed [15:0] den_a;
    logic signed [15:0] num_b;
    logic signed [15:0] den_b;
  } rar_in_t;

  typedef struct packed {
    logic        status;
    logic        negative;
    logic [31:0] whole_part;
    logic [29:0] frac_num;
    logic [30:0] frac_den;
    logic [31:0] reduced_num;
  } rar_out_t;

endpackage

// ===== design/rar_mul.sv =====
// bit-serial shift-add multiplier for operand magnitudes
`timescale 1ns / 1ps

module rar_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rar_pkg::OPM_W-1:0]  mul_a,
  input  logic [rar_pkg::OPM_W-1:0]  mul_b,
  output logic                       done,
  output logic [rar_pkg::PROD_W-1:0] product
);
  import rar_pkg::*;

  localparam int CW = $clog2(OPM_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] mcand_r, mcand_nxt;
  logic [OPM_W-1:0]  mplier_r, mplier_nxt;

  // one multiplier bit per cycle
  always_comb begin
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (start) begin
      run_nxt    = 1'b1;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      mcand_nxt  = PROD_W'(mul_a);
      mplier_nxt = mul_b;
    end else if (run_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CW'(OPM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== design/rar_gcd.sv =====
// iterative binary gcd, one step per cycle
`timescale 1ns / 1ps

module rar_gcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rar_pkg::MAG_W-1:0] u_in,
  input  logic [rar_pkg::MAG_W-1:0] v_in,
  output logic                      done,
  output logic [rar_pkg::MAG_W-1:0] gcd
);
  import rar_pkg::*;

  localparam int KW = $clog2(MAG_W) + 1;

  logic             run_r, run_nxt;
  logic             shl_r, shl_nxt;
  logic             done_r, done_nxt;
  logic [MAG_W-1:0] u_r, u_nxt;
  logic [MAG_W-1:0] v_r, v_nxt;
  logic [MAG_W-1:0] g_r, g_nxt;
  logic [KW-1:0]    k_r, k_nxt;

  // strip common twos, reduce odd parts, then restore the twos serially
  always_comb begin
    run_nxt  = run_r;
    shl_nxt  = shl_r;
    done_nxt = 1'b0;
    u_nxt    = u_r;
    v_nxt    = v_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    if (start) begin
      run_nxt = 1'b1;
      shl_nxt = 1'b0;
      u_nxt   = u_in;
      v_nxt   = v_in;
      k_nxt   = '0;
    end else if (run_r) begin
      if (u_r == '0) begin
        g_nxt   = v_r;
        run_nxt = 1'b0;
        shl_nxt = 1'b1;
      end else if (v_r == '0) begin
        g_nxt   = u_r;
        run_nxt = 1'b0;
        shl_nxt = 1'b1;
      end else if (!u_r[0] && !v_r[0]) begin
        u_nxt = u_r >> 1;
        v_nxt = v_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_nxt = u_r >> 1;
      end else if (!v_r[0]) begin
        v_nxt = v_r >> 1;
      end else if (u_r >= v_r) begin
        u_nxt = u_r - v_r;
      end else begin
        v_nxt = v_r - u_r;
      end
    end else if (shl_r) begin
      if (k_r == '0) begin
        shl_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        g_nxt = g_r << 1;
        k_nxt = k_r - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      shl_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      shl_r  <= shl_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    v_r <= v_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
  end

  assign done = done_r;
  assign gcd  = g_r;

endmodule

// ===== design/rar_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rar_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rar_pkg::MAG_W-1:0] dividend,
  input  logic [rar_pkg::MAG_W-1:0] divisor,
  output logic                      done,
  output logic [rar_pkg::MAG_W-1:0] quotient,
  output logic [rar_pkg::MAG_W-1:0] remainder
);
  import rar_pkg::*;

  localparam int CW = $clog2(MAG_W);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [MAG_W-1:0] quo_r, quo_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] dvs_r, dvs_nxt;
  logic [MAG_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  // shift in one dividend bit, subtract when the divisor fits
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      quo_nxt = {quo_r[MAG_W-2:0], fits};
      rem_nxt = fits ? MAG_W'(trial - {1'b0, dvs_r}) : trial[MAG_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(MAG_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== design/rational_arithmetic_reduce.sv =====
// top level: fraction add, subtract, multiply, divide with gcd reduction
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; busy then stays
// high until the result is out. The result appears for exactly one cycle with
// out_valid high and cannot be held off. A zero denominator, or a divide by a
// zero fraction, returns status 1 in the cycle after the start with no busy time.
// Otherwise one transaction runs three bit-serial products, a binary gcd of one
// step per cycle whose length is set by the operand values, and three restoring
// divisions on the shared divider. A new transaction may start in the cycle its
// predecessor's result is shown.
module rational_arithmetic_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rar_pkg::rar_in_t  in_data,
  output logic              out_valid,
  output rar_pkg::rar_out_t out_data
);
  import rar_pkg::*;
  `include "assert_macros.svh"

  // operands wider than 16 bits take the input as non-negative
  localparam int EW = (OPERAND_WIDTH < 16) ? OPERAND_WIDTH : 16;
  localparam bit SX = (OPERAND_WIDTH <= 16);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_MUL_GO   = 9'b000000010,
    ST_MUL_WAIT = 9'b000000100,
    ST_SUM      = 9'b000001000,
    ST_GCD_GO   = 9'b000010000,
    ST_GCD_WAIT = 9'b000100000,
    ST_DIV_GO   = 9'b001000000,
    ST_DIV_WAIT = 9'b010000000,
    ST_SPARE    = 9'b100000000
  } state_t;

  function automatic logic [OPM_W:0] operand(input logic [15:0] raw);
    logic [OPM_W-1:0] v;
    logic             neg;
    v   = OPM_W'(raw[EW-1:0]);
    neg = SX && raw[EW-1];
    return {neg, neg ? OPM_W'((OPM_W'(1) << EW) - v) : v};
  endfunction

  state_t            state_r, state_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [1:0]        op_r;
  logic [OPM_W:0]    opa_r, opda_r, opb_r, opdb_r;
  logic [OPM_W:0]    opa, opda, opb, opdb;
  logic              undef;
  logic [MAG_W-1:0]  p0_r, p1_r, p2_r;
  logic              s0_r, s1_r, s2_r;
  logic [MAG_W-1:0]  nm_r, dm_r, g_r, rn_r, rd_r;
  logic              neg_r;
  logic              out_valid_r, out_valid_nxt;
  rar_out_t          out_r;
  logic [OPM_W-1:0]  mul_a, mul_b;
  logic              mul_sgn;
  logic              mul_done;
  logic [PROD_W-1:0] product;
  logic              gcd_done;
  logic [MAG_W-1:0]  gcd;
  logic [MAG_W-1:0]  dvd, dvs;
  logic              div_done;
  logic [MAG_W-1:0]  quo, rem;
  logic [MAG_W+1:0]  t0, t1, nsum;
  logic [MAG_W-1:0]  nmag;

  // sign split of the incoming operands
  assign opa   = operand(in_data.num_a);
  assign opda  = operand(in_data.den_a);
  assign opb   = operand(in_data.num_b);
  assign opdb  = operand(in_data.den_b);
  assign undef = (opda[OPM_W-1:0] == '0) || (opdb[OPM_W-1:0] == '0) ||
                 ((in_data.action == ACT_DIV) && (opb[OPM_W-1:0] == '0));

  // product operand selection: numerator terms, then denominator
  always_comb begin
    case (idx_r)
      2'd0: begin
        mul_a   = opa_r[OPM_W-1:0];
        mul_b   = (op_r == ACT_MUL) ? opb_r[OPM_W-1:0] : opdb_r[OPM_W-1:0];
        mul_sgn = opa_r[OPM_W] ^ ((op_r == ACT_MUL) ? opb_r[OPM_W] : opdb_r[OPM_W]);
      end
      2'd1: begin
        mul_a   = opb_r[OPM_W-1:0];
        mul_b   = opda_r[OPM_W-1:0];
        mul_sgn = opb_r[OPM_W] ^ opda_r[OPM_W];
      end
      default: begin
        mul_a   = opda_r[OPM_W-1:0];
        mul_b   = (op_r == ACT_DIV) ? opb_r[OPM_W-1:0] : opdb_r[OPM_W-1:0];
        mul_sgn = opda_r[OPM_W] ^ ((op_r == ACT_DIV) ? opb_r[OPM_W] : opdb_r[OPM_W]);
      end
    endcase
  end

  // signed numerator from the two cross products, or the first product alone for multiply and divide
  always_comb begin
    t0 = s0_r ? (MAG_W+2)'(-{2'b00, p0_r}) : {2'b00, p0_r};
    t1 = s1_r ? (MAG_W+2)'(-{2'b00, p1_r}) : {2'b00, p1_r};
    case (op_r)
      ACT_ADD: nsum = t0 + t1;
      ACT_SUB: nsum = t0 - t1;
      default: nsum = t0;
    endcase
    nmag = nsum[MAG_W+1] ? MAG_W'(-nsum) : nsum[MAG_W-1:0];
  end

  // divider operands: nm/g, dm/g, then the mixed split
  always_comb begin
    case (idx_r)
      2'd0:    begin dvd = nm_r; dvs = g_r;  end
      2'd1:    begin dvd = dm_r; dvs = g_r;  end
      default: begin dvd = rn_r; dvs = rd_r; end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (undef) begin
            out_valid_nxt = 1'b1;
          end else begin
            idx_nxt   = 2'd0;
            state_nxt = ST_MUL_GO;
          end
        end
      end
      ST_MUL_GO:   state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (idx_r == 2'd2) begin
            state_nxt = ST_SUM;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MUL_GO;
          end
        end
      end
      ST_SUM:      state_nxt = ST_GCD_GO;
      ST_GCD_GO:   state_nxt = ST_GCD_WAIT;
      ST_GCD_WAIT: begin
        if (gcd_done) begin
          idx_nxt   = 2'd0;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (idx_r == 2'd2) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operand, intermediate and result registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r   <= in_data.action;
      opa_r  <= opa;
      opda_r <= opda;
      opb_r  <= opb;
      opdb_r <= opdb;
      out_r  <= '{status: 1'b1, default: '0};
    end
    if (state_r == ST_MUL_WAIT && mul_done) begin
      case (idx_r)
        2'd0:    begin p0_r <= product[MAG_W-1:0]; s0_r <= mul_sgn; end
        2'd1:    begin p1_r <= product[MAG_W-1:0]; s1_r <= mul_sgn; end
        default: begin p2_r <= product[MAG_W-1:0]; s2_r <= mul_sgn; end
      endcase
    end
    if (state_r == ST_SUM) begin
      nm_r  <= nmag;
      dm_r  <= p2_r;
      neg_r <= (nmag != '0) && (nsum[MAG_W+1] ^ s2_r);
    end
    if (state_r == ST_GCD_WAIT && gcd_done) begin
      g_r <= gcd;
    end
    if (state_r == ST_DIV_WAIT && div_done) begin
      case (idx_r)
        2'd0:    rn_r <= quo;
        2'd1:    rd_r <= quo;
        default: begin
          out_r <= '{status: 1'b0, negative: neg_r, whole_part: quo[31:0],
                     frac_num: rem[29:0], frac_den: rd_r[30:0],
                     reduced_num: rn_r[31:0]};
        end
      endcase
    end
  end

  rar_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_MUL_GO),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .done    (mul_done),
    .product (product)
  );

  rar_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_GCD_GO),
    .u_in  (nm_r),
    .v_in  (dm_r),
    .done  (gcd_done),
    .gcd   (gcd)
  );

  rar_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_DIV_GO),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result only follows a transaction in flight or just taken
  `RAR_ASSERT(a_out_after_work, out_valid |-> ($past(busy) || $past(start)))
  // the block is free again when a result is shown
  `RAR_ASSERT(a_out_idle, out_valid |-> !busy)
  // an undefined result carries no sign
  `RAR_NEVER(a_undef_clean, out_valid && out_data.status && out_data.negative)

endmodule

// ===== bench/rar_checker.sv =====
// checker for the fraction arithmetic block: predicts each result and compares
`timescale 1ns / 1ps

module rar_checker #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  rar_pkg::rar_in_t  in_data,
  input  logic              out_valid,
  input  rar_pkg::rar_out_t out_data,
  output int                fail_count,
  output int                pending
);
  import rar_pkg::*;

  rar_out_t fraction_q[$];

  // sign-extend one operand from the configured width; wider than 16 bits it is taken as non-negative
  function automatic longint operand_value(logic [15:0] raw);
    longint v;
    v = raw;
    if (OPERAND_WIDTH < 16) v = v & ((64'd1 << OPERAND_WIDTH) - 1);
    if (OPERAND_WIDTH <= 16 && v[OPERAND_WIDTH-1]) v = v - (64'sd1 <<< OPERAND_WIDTH);
    return v;
  endfunction

  // work out the reduced mixed fraction for one transaction
  function automatic rar_out_t reduce_fraction(rar_in_t t);
    rar_out_t r;
    longint a, da, b, db, n, d;
    longint unsigned nm, dm, g, x, y, tmp, rn, rd;
    a = operand_value(t.num_a);
    da = operand_value(t.den_a);
    b = operand_value(t.num_b);
    db = operand_value(t.den_b);
    r = '0;
    if (da == 0 || db == 0 || (t.action == ACT_DIV && b == 0)) begin
      r.status = 1'b1;
      return r;
    end
    case (t.action)
      ACT_ADD: begin n = a * db + b * da; d = da * db; end
      ACT_SUB: begin n = a * db - b * da; d = da * db; end
      ACT_MUL: begin n = a * b; d = da * db; end
      default: begin n = a * db; d = da * b; end
    endcase
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    x = nm;
    y = dm;
    while (y != 0) begin
      tmp = x % y;
      x = y;
      y = tmp;
    end
    g = (x == 0) ? 1 : x;
    rn = nm / g;
    rd = dm / g;
    if (rd == 0) rd = 1;
    r.negative = (nm != 0) && ((n < 0) != (d < 0));
    r.whole_part = 32'(rn / rd);
    r.frac_num = 30'(rn % rd);
    r.frac_den = 31'(rd);
    r.reduced_num = 32'(rn);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = fraction_q.size();

  // predict on accepted transactions, compare on results
  always @(posedge clk) begin
    rar_out_t want;
    if (!rst_n) begin
      fraction_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (fraction_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = fraction_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.negative !== want.negative)
            report_mismatch("negative", out_data.negative, want.negative);
          if (out_data.whole_part !== want.whole_part)
            report_mismatch("whole_part", out_data.whole_part, want.whole_part);
          if (out_data.frac_num !== want.frac_num)
            report_mismatch("frac_num", out_data.frac_num, want.frac_num);
          if (out_data.frac_den !== want.frac_den)
            report_mismatch("frac_den", out_data.frac_den, want.frac_den);
          if (out_data.reduced_num !== want.reduced_num)
            report_mismatch("reduced_num", out_data.reduced_num, want.reduced_num);
        end
      end
      if (start && !busy) fraction_q.push_back(reduce_fraction(in_data));
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// testbench top: stimulus, watchdog and verdict for the fraction arithmetic block
`timescale 1ns / 1ps

module tb_top;
  import rar_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rar_in_t  in_data;
  logic     out_valid;
  rar_out_t out_data;
  int       fail_count;
  int       pending;
  int       idle_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  rational_arithmetic_reduce DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  rar_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // count cycles with no transaction and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  // random operand, often from the edges of the range
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 6)) - 3);
      4: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // hold off, then present one transaction until taken
  task automatic send_fraction(logic [1:0] act, logic [15:0] na, logic [15:0] da,
                               logic [15:0] nb, logic [15:0] db);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{action: act, num_a: na, den_a: da, num_b: nb, den_b: db};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [1:0] act;
    int k;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: each operation, extremes, zero denominators, zero divisor
    send_fraction(ACT_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_fraction(ACT_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_fraction(ACT_MUL, -16'd3, 16'd4, 16'd2, -16'd9);
    send_fraction(ACT_DIV, 16'd7, 16'd3, -16'd2, 16'd5);
    send_fraction(ACT_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fraction(ACT_SUB, 16'h8000, 16'd1, 16'h7fff, 16'd1);
    send_fraction(ACT_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1);
    send_fraction(ACT_DIV, 16'h8000, 16'd1, 16'd1, 16'h8000);
    send_fraction(ACT_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_fraction(ACT_DIV, 16'h7fff, 16'd1, 16'd1, 16'h7fff);
    send_fraction(ACT_ADD, 16'd5, 16'd0, 16'd1, 16'd2);
    send_fraction(ACT_MUL, 16'd5, 16'd3, 16'd1, 16'd0);
    send_fraction(ACT_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
    send_fraction(ACT_DIV, 16'd0, 16'd3, 16'd2, 16'd7);
    send_fraction(ACT_MUL, 16'd0, -16'd3, 16'd2, 16'd7);
    send_fraction(ACT_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fraction(ACT_SUB, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    // random part
    for (k = 0; k < 850; k++) begin
      act = 2'($urandom_range(0, 3));
      send_fraction(act, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/rar_pkg.sv
design/rar_mul.sv
design/rar_gcd.sv
design/rar_div.sv
design/rational_arithmetic_reduce.sv
bench/rar_checker.sv
bench/tb_top.sv
